// ===== sv/pswt_pkg.sv =====
// Shared types and constants for the plucked-string wavetable synth.
// No dependencies; imported by every module of the block.
`default_nettype none

package pswt_pkg;

   // Wavetable geometry (power of two: positions wrap by truncation)
   localparam int TABLE_SIZE = 512;
   localparam int IDX_W      = $clog2(TABLE_SIZE);

   // Default sample width, Q1.(SAMPLE_BITS-1)
   localparam int DEF_SAMPLE_BITS = 16;

   // Register field widths
   localparam int STEP_W = 9;
   localparam int FRAC_W = 16;
   localparam int GAIN_W = 15;
   localparam int THR_W  = 32;

   // Configuration bus
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // Register reset values
   localparam logic [STEP_W-1:0] RST_PHASE_STEP     = STEP_W'(5);
   localparam logic [FRAC_W-1:0] RST_PHASE_FRACTION = FRAC_W'(7209);
   localparam logic [GAIN_W-1:0] RST_SMOOTH_GAIN    = GAIN_W'(32767);
   localparam logic [THR_W-1:0]  RST_SMOOTH_THR     = 32'hFFFF_FFFF;
   localparam logic [THR_W-1:0]  RST_BLEND_THR      = 32'h0000_0000;

   // Item kinds
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   // Register map, byte address 4*index
   typedef enum logic [2:0] {
      REG_PHASE_STEP     = 3'd0,
      REG_PHASE_FRACTION = 3'd1,
      REG_SMOOTH_GAIN    = 3'd2,
      REG_SMOOTH_THR     = 3'd3,
      REG_BLEND_THR      = 3'd4
   } pswt_reg_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_EMIT,
      ST_SUM,
      ST_MUL,
      ST_WRITE
   } pswt_state_type;

   // Configuration handed from the register file to the engine
   typedef struct packed {
      logic [STEP_W-1:0] phase_step;
      logic [FRAC_W-1:0] phase_fraction;
      logic [GAIN_W-1:0] smoothing_gain;
      logic [THR_W-1:0]  smoothing_threshold;
      logic [THR_W-1:0]  blend_threshold;
   } pswt_cfg_type;

endpackage

`default_nettype wire

// ===== sv/pswt_table.sv =====
// Wavetable storage: one write port, one read port, registered read data.
// Depends on pswt_pkg for the table geometry.
`default_nettype none

module pswt_table
   import pswt_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [IDX_W-1:0]       wr_addr,
   input  wire logic [SAMPLE_BITS-1:0] wr_data,
   input  wire logic [IDX_W-1:0]       rd_addr,
   output logic      [SAMPLE_BITS-1:0] rd_data
);

   logic [SAMPLE_BITS-1:0] mem [TABLE_SIZE];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered, read-before-write
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/pswt_engine.sv =====
// Sequencer and datapath: table clear, load, blend, advance, smoothing.
// Depends on pswt_pkg; drives the pswt_table ports and the result beat.
`default_nettype none

module pswt_engine
   import pswt_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pswt_cfg_type                  cfg,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_action,
   input  wire logic [IDX_W-1:0]              req_load_index,
   input  wire logic signed [SAMPLE_BITS-1:0] req_noise_sample,
   input  wire logic [THR_W-1:0]              req_random_blend,
   input  wire logic [THR_W-1:0]              req_random_smooth,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample,
   // table ports
   output logic                               mem_wr_en,
   output logic [IDX_W-1:0]                   mem_wr_addr,
   output logic [SAMPLE_BITS-1:0]             mem_wr_data,
   output logic [IDX_W-1:0]                   mem_rd_addr,
   input  wire logic [SAMPLE_BITS-1:0]        mem_rd_data
);

   localparam int SUM_W  = SAMPLE_BITS + 1;
   localparam int GS_W   = GAIN_W + 2;
   localparam int PROD_W = SUM_W + GS_W;

   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX =
      {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN =
      {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   pswt_state_type state_ff, state_in;

   logic [IDX_W-1:0]              pos_ff, pos_in;
   logic [FRAC_W-1:0]             acc_ff, acc_in;
   logic [IDX_W-1:0]              cur_ff, cur_in;
   logic [IDX_W-1:0]              k_ff, k_in;
   logic [IDX_W-1:0]              clr_ff, clr_in;
   logic                          blend_ff, blend_in;
   logic                          smooth_ff, smooth_in;
   logic                          move_ff, move_in;
   logic signed [SAMPLE_BITS-1:0] val_ff, val_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;

   logic signed [SAMPLE_BITS-1:0] rd_val;
   logic signed [SAMPLE_BITS-1:0] blended;
   logic [FRAC_W:0]               acc_sum;
   logic [IDX_W-1:0]              next_pos;
   logic signed [GS_W-1:0]        gain_s;
   logic                          out_free;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         acc_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      k_ff          <= k_in;
      blend_ff      <= blend_in;
      smooth_ff     <= smooth_in;
      move_ff       <= move_in;
      val_ff        <= val_in;
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // datapath terms
   assign rd_val   = $signed(mem_rd_data);
   assign blended  = blend_ff ? ((rd_val == SMP_MIN) ? SMP_MAX : -rd_val) : rd_val;
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, cfg.phase_fraction};
   assign next_pos = pos_ff + cfg.phase_step[IDX_W-1:0] + IDX_W'(acc_sum[FRAC_W]);
   assign gain_s   = $signed({2'b00, cfg.smoothing_gain});
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // the table is always read at the read position: the current entry
   // before the advance, the new entry after it
   assign mem_rd_addr = pos_ff;

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      k_in          = k_ff;
      blend_in      = blend_ff;
      smooth_in     = smooth_ff;
      move_in       = move_ff;
      val_in        = val_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = k_ff;
      mem_wr_data   = prod_ff[SAMPLE_BITS+FRAC_W-1:FRAC_W];
      req_stall     = 1'b1;

      unique case (state_ff)
         // zero the table after reset, one entry a cycle
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         // take a beat; loads write straight into the table
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_action == ACT_LOAD) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = req_load_index;
                  mem_wr_data = req_noise_sample;
               end else begin
                  blend_in  = req_random_blend < cfg.blend_threshold;
                  smooth_in = req_random_smooth <= cfg.smoothing_threshold;
                  state_in  = ST_FETCH;
               end
            end
         end
         // current entry is here: blend, write back if blended, advance
         ST_FETCH: begin
            mem_wr_en   = blend_ff;
            mem_wr_addr = pos_ff;
            mem_wr_data = blended;
            val_in      = blended;
            cur_in      = pos_ff;
            pos_in      = next_pos;
            acc_in      = acc_sum[FRAC_W-1:0];
            move_in     = next_pos != pos_ff;
            state_in    = ST_EMIT;
         end
         // hand the sample to the output register; new entry is being read
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = val_ff;
               state_in      = (move_ff && smooth_ff) ? ST_SUM : ST_IDLE;
            end
         end
         ST_SUM: begin
            sum_in   = SUM_W'(val_ff) + SUM_W'(rd_val);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(sum_ff) * PROD_W'(gain_s);
            k_in     = cur_ff;
            state_in = ST_WRITE;
         end
         // fill old..new position (inclusive, circular) with the mean
         ST_WRITE: begin
            mem_wr_en = 1'b1;
            k_in      = k_ff + IDX_W'(1);
            if (k_ff == pos_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

`default_nettype wire

// ===== sv/plucked_string_wavetable_synth.sv =====
// Top level: configuration registers, sequencer and wavetable memory.
// Depends on pswt_pkg, pswt_engine and pswt_table.
`default_nettype none

// Karplus-Strong plucked-string voice over a 512-entry circular table held
// in one single-port-write synchronous memory. After reset the table is
// zeroed by a clearing pass, during which req_stall is high; register
// writes are taken at any time. A load beat (action 1) writes one entry.
// A tick beat (action 0) blends, emits and advances; when smoothing
// happens, it goes on through sum, multiply and write states: the table's
// single write port rewrites every entry from the old to the new position,
// a circular distance of step plus fractional carry, one per cycle. The
// sample sits in an output register, so the block goes on smoothing while
// the sample waits; a tick only waits if the previous sample is still held.
module plucked_string_wavetable_synth
   import pswt_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_action,
   input  wire logic [IDX_W-1:0]              req_load_index,
   input  wire logic signed [SAMPLE_BITS-1:0] req_noise_sample,
   input  wire logic [THR_W-1:0]              req_random_blend,
   input  wire logic [THR_W-1:0]              req_random_smooth,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample,
   // configuration port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [CSR_ADDR_W-1:0]         paddr,
   input  wire logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]              prdata,
   output logic                               pready
);

   pswt_cfg_type cfg_ff, cfg_in;
   pswt_reg_type reg_idx;
   logic         csr_wr;

   logic                   mem_wr_en;
   logic [IDX_W-1:0]       mem_wr_addr;
   logic [SAMPLE_BITS-1:0] mem_wr_data;
   logic [IDX_W-1:0]       mem_rd_addr;
   logic [SAMPLE_BITS-1:0] mem_rd_data;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign reg_idx = pswt_reg_type'(paddr[4:2]);

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            REG_PHASE_STEP:     cfg_in.phase_step          = pwdata[STEP_W-1:0];
            REG_PHASE_FRACTION: cfg_in.phase_fraction      = pwdata[FRAC_W-1:0];
            REG_SMOOTH_GAIN:    cfg_in.smoothing_gain      = pwdata[GAIN_W-1:0];
            REG_SMOOTH_THR:     cfg_in.smoothing_threshold = pwdata[THR_W-1:0];
            REG_BLEND_THR:      cfg_in.blend_threshold     = pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step          <= RST_PHASE_STEP;
         cfg_ff.phase_fraction      <= RST_PHASE_FRACTION;
         cfg_ff.smoothing_gain      <= RST_SMOOTH_GAIN;
         cfg_ff.smoothing_threshold <= RST_SMOOTH_THR;
         cfg_ff.blend_threshold     <= RST_BLEND_THR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read mux
   always_comb begin
      unique case (reg_idx)
         REG_PHASE_STEP:     prdata = CSR_DATA_W'(cfg_ff.phase_step);
         REG_PHASE_FRACTION: prdata = CSR_DATA_W'(cfg_ff.phase_fraction);
         REG_SMOOTH_GAIN:    prdata = CSR_DATA_W'(cfg_ff.smoothing_gain);
         REG_SMOOTH_THR:     prdata = CSR_DATA_W'(cfg_ff.smoothing_threshold);
         REG_BLEND_THR:      prdata = CSR_DATA_W'(cfg_ff.blend_threshold);
         default:            prdata = '0;
      endcase
   end

   pswt_engine #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_load_index   (req_load_index),
      .req_noise_sample (req_noise_sample),
      .req_random_blend (req_random_blend),
      .req_random_smooth(req_random_smooth),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data)
   );

   pswt_table #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_table (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

endmodule

`default_nettype wire

// ===== sv/pswt_checker.sv =====
// Port-level checks for the plucked-string synth, bound to the top level.
// Depends on pswt_pkg for widths and item kinds.
`default_nettype none

module pswt_checker
   import pswt_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   req_action,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [SAMPLE_BITS-1:0] rsp_sample
);

   // a held result beat keeps its sample
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample))
      else $error("result beat dropped or changed while stalled");

   // the table clearing pass follows every reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request taken during table clear");

   // a load never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACT_LOAD) && !rsp_valid
      |=> !rsp_valid)
      else $error("result beat after a load");

   // a tick keeps the block busy in the following cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACT_TICK) |=> req_stall)
      else $error("request taken while a tick is in flight");

endmodule

bind plucked_string_wavetable_synth pswt_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_pswt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_action(req_action),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_sample(rsp_sample)
);

`default_nettype wire

// ===== tb/plucked_string_wavetable_synth_tb.sv =====
// Self-checking testbench for plucked_string_wavetable_synth: directed and random
// loads and ticks, checked against a string model kept inside the bench.
// Depends on pswt_pkg and the plucked_string_wavetable_synth RTL.
`default_nettype none

module plucked_string_wavetable_synth_tb;
   import pswt_pkg::*;

   localparam int SB = DEF_SAMPLE_BITS;
   localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};
   localparam logic signed [SB-1:0] SMP_MAX = ~SMP_MIN;
   // Drain and watchdog allow for a smoothing tick over a whole table, for
   // the clear after reset, and for stalls.
   localparam int DRAIN_CYCLES = 600;
   localparam int QUIET_LIMIT  = 5000;

   typedef struct {
      logic               action;
      logic [IDX_W-1:0]   index;
      logic signed [SB-1:0] noise;
      logic [THR_W-1:0]   rnd_blend;
      logic [THR_W-1:0]   rnd_smooth;
   } string_req_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall, req_action;
   logic [IDX_W-1:0] req_load_index;
   logic signed [SB-1:0] req_noise_sample;
   logic [THR_W-1:0] req_random_blend, req_random_smooth;
   logic rsp_valid, rsp_stall;
   logic signed [SB-1:0] rsp_sample;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   // String model: table, position, fraction accumulator and register copies
   logic signed [SB-1:0] string_tbl [TABLE_SIZE];
   logic [IDX_W-1:0]  str_pos;
   logic [FRAC_W-1:0] str_acc;
   logic [STEP_W-1:0] m_step;
   logic [FRAC_W-1:0] m_frac;
   logic [GAIN_W-1:0] m_gain;
   logic [THR_W-1:0]  m_smooth_thr;
   logic [THR_W-1:0]  m_blend_thr;

   logic signed [SB-1:0] expected_samples [$];
   int mismatches = 0;
   int quiet_cycles = 0;
   int send_gap_pct = 0;
   int recv_stall_pct = 0;

   plucked_string_wavetable_synth i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_load_index    (req_load_index),
      .req_noise_sample  (req_noise_sample),
      .req_random_blend  (req_random_blend),
      .req_random_smooth (req_random_smooth),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample        (rsp_sample),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Model update for one accepted request beat; ticks queue their sample
   task automatic advance_string(input string_req_type it);
      logic [IDX_W-1:0] cur, nxt, k;
      logic [FRAC_W:0] acc_sum;
      logic signed [SB:0] pair_sum;
      logic signed [47:0] prod;
      logic signed [SB-1:0] mean;
      if (it.action == ACT_LOAD) begin
         string_tbl[it.index] = it.noise;
         return;
      end
      cur = str_pos;
      // blend: sign flip, most negative value saturates to most positive
      if (it.rnd_blend < m_blend_thr) begin
         string_tbl[cur] = (string_tbl[cur] == SMP_MIN) ? SMP_MAX : -string_tbl[cur];
      end
      expected_samples.push_back(string_tbl[cur]);
      // advance; index width wraps modulo the table size
      acc_sum = {1'b0, str_acc} + {1'b0, m_frac};
      nxt = cur + m_step + IDX_W'(acc_sum[FRAC_W]);
      str_acc = acc_sum[FRAC_W-1:0];
      str_pos = nxt;
      // smooth old..new inclusive, gain is Q0.16, floor on the shift
      if (nxt != cur && it.rnd_smooth <= m_smooth_thr) begin
         pair_sum = (SB+1)'(string_tbl[cur]) + (SB+1)'(string_tbl[nxt]);
         prod = 48'(pair_sum) * 48'($signed({1'b0, m_gain}));
         mean = prod[SB+15:16];
         k = cur;
         forever begin
            string_tbl[k] = mean;
            if (k == nxt) break;
            k = k + IDX_W'(1);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic signed [SB-1:0] want,
                                  input logic signed [SB-1:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("sample mismatch (%s): expected %0d, got %0d", what, want, got);
      end
   endtask

   // Result checker: each beat against the oldest expected sample
   always @(posedge clock) begin : check_samples
      logic signed [SB-1:0] want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected beat", 'x, rsp_sample);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want) report_mismatch("sample", want, rsp_sample);
         end
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Present one request beat, wait for it to be taken, update the model
   task automatic send_beat(input string_req_type it);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= it.action;
      req_load_index    <= it.index;
      req_noise_sample  <= it.noise;
      req_random_blend  <= it.rnd_blend;
      req_random_smooth <= it.rnd_smooth;
      do @(posedge clock); while (req_stall);
      advance_string(it);
   endtask

   function automatic string_req_type tick_beat(input logic [THR_W-1:0] rb,
                                                input logic [THR_W-1:0] rs);
      string_req_type it;
      it.action     = ACT_TICK;
      it.index      = IDX_W'($urandom);
      it.noise      = SB'($urandom);
      it.rnd_blend  = rb;
      it.rnd_smooth = rs;
      return it;
   endfunction

   function automatic string_req_type load_beat(input logic [IDX_W-1:0] idx,
                                                input logic signed [SB-1:0] val);
      string_req_type it;
      it.action     = ACT_LOAD;
      it.index      = idx;
      it.noise      = val;
      it.rnd_blend  = $urandom;
      it.rnd_smooth = $urandom;
      return it;
   endfunction

   // Wait for every expected sample, then for any trailing smoothing pass
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, access cycle until pready, then return to idle
   task automatic write_reg(input pswt_reg_type r, input logic [CSR_DATA_W-1:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (r)
         REG_PHASE_STEP:     m_step       = v[STEP_W-1:0];
         REG_PHASE_FRACTION: m_frac       = v[FRAC_W-1:0];
         REG_SMOOTH_GAIN:    m_gain       = v[GAIN_W-1:0];
         REG_SMOOTH_THR:     m_smooth_thr = v[THR_W-1:0];
         REG_BLEND_THR:      m_blend_thr  = v[THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_pacing(input int gap_pct, input int stall_pct);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
   endtask

   // Ticks straight out of reset: zero table, default registers
   task automatic test_reset_defaults();
      send_beat(tick_beat('0, '1));
      send_beat(tick_beat('0, '1));
   endtask

   // Loads at both ends of the sample range and the index range
   task automatic test_load_extremes();
      send_beat(load_beat(str_pos, SMP_MIN));
      send_beat(load_beat(str_pos + 9'd5, SMP_MAX));
      send_beat(load_beat('1, SMP_MAX));
      send_beat(load_beat('0, SMP_MIN));
      send_beat(tick_beat('0, '1));
      send_beat(tick_beat('0, '1));
   endtask

   // Negation of the most negative entry saturates; top random word never negates
   task automatic test_blend_saturation();
      settle();
      write_reg(REG_BLEND_THR, 32'hFFFF_FFFF);
      write_reg(REG_SMOOTH_THR, 32'h0);
      send_beat(load_beat(str_pos, SMP_MIN));
      send_beat(tick_beat('0, 32'h1));
      send_beat(load_beat(str_pos, SMP_MIN));
      send_beat(tick_beat('1, 32'h1));
   endtask

   // Smoothing at the threshold, zero gain, negative floor rounding
   task automatic test_smoothing_rule();
      settle();
      write_reg(REG_BLEND_THR, 32'h0);
      send_beat(load_beat(str_pos, 16'sd1000));
      send_beat(load_beat(str_pos + 9'd5, 16'sd3000));
      send_beat(tick_beat('0, 32'h0));
      settle();
      write_reg(REG_SMOOTH_GAIN, 32'h0);
      send_beat(tick_beat('0, 32'h0));
      settle();
      write_reg(REG_SMOOTH_GAIN, 32'h7FFF);
      send_beat(load_beat(str_pos, -16'sd1));
      send_beat(tick_beat('0, 32'h0));
   endtask

   // Largest step with carry (full turn, no smoothing), then no motion at all
   task automatic test_phase_extremes();
      settle();
      write_reg(REG_PHASE_STEP, 32'd511);
      write_reg(REG_PHASE_FRACTION, 32'hFFFF);
      write_reg(REG_SMOOTH_THR, 32'hFFFF_FFFF);
      repeat (3) send_beat(tick_beat($urandom, $urandom));
      settle();
      write_reg(REG_PHASE_STEP, 32'd0);
      write_reg(REG_PHASE_FRACTION, 32'd0);
      repeat (2) send_beat(tick_beat($urandom, $urandom));
   endtask

   function automatic logic [31:0] pick_level(input logic [31:0] top);
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return top;
         default: return $urandom & top;
      endcase
   endfunction

   // Random words land on either side of a threshold, often right at it
   function automatic logic [31:0] near_level(input logic [31:0] thr);
      if ($urandom_range(0, 3) == 0) return thr + $urandom_range(0, 2) - 1;
      return $urandom;
   endfunction

   // Random phases: pluck a burst at the read position, then mixed beats
   task automatic test_random_plucks();
      string_req_type it;
      int n_items;
      for (int ph = 0; ph < 9; ph++) begin
         settle();
         case (ph / 3)
            0:       set_pacing(20, 62);
            1:       set_pacing(62, 20);
            default: set_pacing(0, 0);
         endcase
         write_reg(REG_PHASE_STEP, (ph == 4) ? $urandom_range(500, 511) : $urandom_range(0, 12));
         write_reg(REG_PHASE_FRACTION, pick_level(32'hFFFF));
         write_reg(REG_SMOOTH_GAIN, pick_level(32'h7FFF));
         write_reg(REG_SMOOTH_THR, pick_level(32'hFFFF_FFFF));
         write_reg(REG_BLEND_THR, pick_level(32'hFFFF_FFFF));
         n_items = (ph == 4) ? 30 : 220;
         for (int i = 0; i < 24; i++) begin
            send_beat(load_beat(str_pos + IDX_W'(i), SB'($urandom)));
         end
         for (int i = 0; i < n_items; i++) begin
            it = tick_beat(near_level(m_blend_thr), near_level(m_smooth_thr));
            if ($urandom_range(0, 99) < 25) begin
               it.action = ACT_LOAD;
            end
            send_beat(it);
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_action        <= ACT_TICK;
      req_load_index    <= '0;
      req_noise_sample  <= '0;
      req_random_blend  <= '0;
      req_random_smooth <= '0;
      rsp_stall         <= 1'b0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      foreach (string_tbl[i]) string_tbl[i] = '0;
      str_pos      = '0;
      str_acc      = '0;
      m_step       = RST_PHASE_STEP;
      m_frac       = RST_PHASE_FRACTION;
      m_gain       = RST_SMOOTH_GAIN;
      m_smooth_thr = RST_SMOOTH_THR;
      m_blend_thr  = RST_BLEND_THR;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      set_pacing(20, 62);
      test_reset_defaults();
      test_load_extremes();
      test_blend_saturation();
      test_smoothing_rule();
      test_phase_extremes();
      test_random_plucks();
      settle();

      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
